// ===== hdl/gxpe_pkg.sv =====
// Shared types and constants for the GF(2) XOR program evaluator.
// Used by the controller, datapath and top level; depends on nothing.
package gxpe_pkg;

  // Sizes of the entry table and its fields
  localparam int MAX_BITS    = 32;
  localparam int MAX_APPENDS = 128;
  localparam int VEC_W       = MAX_BITS;
  localparam int UNIT_W      = $clog2(MAX_BITS);
  localparam int BASE_W      = 6;
  localparam int IDX_W       = 8;
  localparam int CNT_W       = $clog2(MAX_APPENDS + 1);
  localparam int ADDR_W      = $clog2(MAX_APPENDS);
  localparam int STAT_W      = 2;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(23);

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Item kinds carried on the input tuser
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Which result the datapath loads into its output register
  typedef enum logic [2:0] {
    RES_BAD,
    RES_FULL,
    RES_UNIT,
    RES_SCAN,
    RES_MISS
  } res_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     load;       // latch accepted input transaction
    logic     rd_first;   // issue memory read of the first operand
    logic     take_first; // hold the first operand vector, read the second
    logic     commit;     // write the XOR and load the append result
    logic     scan_start; // clear scan pointer, read slot 0
    logic     scan_next;  // advance scan pointer, read next slot
    logic     res_we;     // load a result chosen by res_sel
    res_sel_t res_sel;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_query;
    logic bad_index;
    logic full;
    logic unit_hit;
    logic empty;
    logic scan_hit;
    logic scan_last;
  } sts_t;

endpackage

// ===== hdl/gxpe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the appended entry vectors.
module gxpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/gxpe_ctrl.sv =====
// Sequencing state machine for the evaluator: handshakes and datapath commands.
// Depends on gxpe_pkg for the command and status structs.
module gxpe_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  gxpe_pkg::sts_t  sts,
  output gxpe_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_RD_A   = 6'b000100,
    S_RD_B   = 6'b001000,
    S_SCAN   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.res_sel = gxpe_pkg::RES_MISS;
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_query) begin
          if (sts.unit_hit) begin
            cmd.res_we  = 1'b1;
            cmd.res_sel = gxpe_pkg::RES_UNIT;
            state_nxt   = S_DONE;
          end else if (sts.empty) begin
            cmd.res_we  = 1'b1;
            cmd.res_sel = gxpe_pkg::RES_MISS;
            state_nxt   = S_DONE;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end else if (sts.bad_index) begin
          cmd.res_we  = 1'b1;
          cmd.res_sel = gxpe_pkg::RES_BAD;
          state_nxt   = S_DONE;
        end else if (sts.full) begin
          cmd.res_we  = 1'b1;
          cmd.res_sel = gxpe_pkg::RES_FULL;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_first = 1'b1;
          state_nxt    = S_RD_A;
        end
      end
      S_RD_A: begin
        cmd.take_first = 1'b1;
        state_nxt      = S_RD_B;
      end
      S_RD_B: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_SCAN: begin
        if (sts.scan_hit) begin
          cmd.res_we  = 1'b1;
          cmd.res_sel = gxpe_pkg::RES_SCAN;
          state_nxt   = S_DONE;
        end else if (sts.scan_last) begin
          cmd.res_we  = 1'b1;
          cmd.res_sel = gxpe_pkg::RES_MISS;
          state_nxt   = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_DONE: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/gxpe_dp.sv =====
// Datapath of the evaluator: item registers, entry memory, counters, result.
// Depends on gxpe_pkg and instantiates gxpe_ram.
module gxpe_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gxpe_pkg::BASE_W-1:0]    cfg_wdata,
  input  logic                           in_kind,
  input  logic [gxpe_pkg::IDX_W-1:0]     in_first,
  input  logic [gxpe_pkg::IDX_W-1:0]     in_second,
  input  logic [gxpe_pkg::VEC_W-1:0]     in_target,
  input  gxpe_pkg::cmd_t                 cmd,
  output gxpe_pkg::sts_t                 sts,
  output logic [gxpe_pkg::STAT_W-1:0]    res_status,
  output logic [gxpe_pkg::IDX_W-1:0]     res_index,
  output logic [gxpe_pkg::VEC_W-1:0]     res_vector
);

  logic [gxpe_pkg::BASE_W-1:0]  base_r;
  logic [gxpe_pkg::CNT_W-1:0]   count_r;
  logic                         kind_r;
  logic [gxpe_pkg::IDX_W-1:0]   first_r;
  logic [gxpe_pkg::IDX_W-1:0]   second_r;
  logic [gxpe_pkg::VEC_W-1:0]   target_r;
  logic [gxpe_pkg::VEC_W-1:0]   vec_a_r;
  logic [gxpe_pkg::CNT_W-1:0]   ptr_r;
  logic [gxpe_pkg::STAT_W-1:0]  status_r;
  logic [gxpe_pkg::IDX_W-1:0]   index_r;
  logic [gxpe_pkg::VEC_W-1:0]   vector_r;

  logic [gxpe_pkg::BASE_W-1:0]  units;
  logic [gxpe_pkg::IDX_W-1:0]   units_ext;
  logic [gxpe_pkg::IDX_W-1:0]   total;
  logic [gxpe_pkg::IDX_W-1:0]   first_off;
  logic [gxpe_pkg::IDX_W-1:0]   second_off;
  logic                         first_unit;
  logic                         second_unit;
  logic [gxpe_pkg::VEC_W-1:0]   first_vec;
  logic [gxpe_pkg::VEC_W-1:0]   second_vec;
  logic [gxpe_pkg::VEC_W-1:0]   new_vec;
  logic [gxpe_pkg::UNIT_W-1:0]  unit_pos;
  logic [gxpe_pkg::CNT_W-1:0]   ptr_inc;
  logic [gxpe_pkg::ADDR_W-1:0]  raddr;
  logic [gxpe_pkg::VEC_W-1:0]   rdata;

  // Clamp base count to the supported range
  always_comb begin
    if (base_r == '0) begin
      units = gxpe_pkg::BASE_W'(1);
    end else if (base_r > gxpe_pkg::BASE_W'(gxpe_pkg::MAX_BITS)) begin
      units = gxpe_pkg::BASE_W'(gxpe_pkg::MAX_BITS);
    end else begin
      units = base_r;
    end
  end

  assign units_ext  = gxpe_pkg::IDX_W'(units);
  assign total      = units_ext + gxpe_pkg::IDX_W'(count_r);
  assign first_off  = first_r - units_ext;
  assign second_off = second_r - units_ext;
  assign first_unit  = (first_r < units_ext);
  assign second_unit = (second_r < units_ext);
  assign ptr_inc    = ptr_r + gxpe_pkg::CNT_W'(1);

  // Bit position of a one-hot target
  always_comb begin
    unit_pos = '0;
    for (int i = 0; i < gxpe_pkg::VEC_W; i++) begin
      if (target_r[i]) begin
        unit_pos = unit_pos | gxpe_pkg::UNIT_W'(i);
      end
    end
  end

  // Operand vectors: unit vectors are built, appended ones come from memory
  assign first_vec  = first_unit ? (gxpe_pkg::VEC_W'(1) << first_r[gxpe_pkg::UNIT_W-1:0])
                                 : rdata;
  assign second_vec = second_unit ? (gxpe_pkg::VEC_W'(1) << second_r[gxpe_pkg::UNIT_W-1:0])
                                  : rdata;
  assign new_vec    = vec_a_r ^ second_vec;

  // Select memory read address
  always_comb begin
    raddr = ptr_inc[gxpe_pkg::ADDR_W-1:0];
    if (cmd.rd_first) begin
      raddr = first_off[gxpe_pkg::ADDR_W-1:0];
    end else if (cmd.take_first) begin
      raddr = second_off[gxpe_pkg::ADDR_W-1:0];
    end else if (cmd.scan_start) begin
      raddr = '0;
    end
  end

  gxpe_ram #(
    .WIDTH (gxpe_pkg::VEC_W),
    .DEPTH (gxpe_pkg::MAX_APPENDS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (count_r[gxpe_pkg::ADDR_W-1:0]),
    .wdata (new_vec),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Status back to the controller
  always_comb begin
    sts.is_query  = (kind_r == gxpe_pkg::KIND_QUERY);
    sts.bad_index = (first_r >= total) || (second_r >= total);
    sts.full      = (count_r == gxpe_pkg::CNT_W'(gxpe_pkg::MAX_APPENDS));
    sts.unit_hit  = (target_r != '0) && ((target_r & (target_r - gxpe_pkg::VEC_W'(1))) == '0)
                    && ((target_r >> units) == '0);
    sts.empty     = (count_r == '0);
    sts.scan_hit  = (rdata == target_r);
    sts.scan_last = (ptr_inc == count_r);
  end

  // Configuration and append counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= gxpe_pkg::BASE_RESET;
      count_r <= '0;
    end else if (cfg_we) begin
      base_r  <= cfg_wdata;
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_r + gxpe_pkg::CNT_W'(1);
    end
  end

  // Item, operand and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      first_r  <= in_first;
      second_r <= in_second;
      target_r <= in_target;
    end
    if (cmd.take_first) begin
      vec_a_r <= first_vec;
    end
    if (cmd.scan_start) begin
      ptr_r <= '0;
    end else if (cmd.scan_next) begin
      ptr_r <= ptr_inc;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= gxpe_pkg::ST_OK;
      index_r  <= total;
      vector_r <= new_vec;
    end else if (cmd.res_we) begin
      case (cmd.res_sel)
        gxpe_pkg::RES_BAD: begin
          status_r <= gxpe_pkg::ST_BAD_INDEX;
          index_r  <= '0;
          vector_r <= '0;
        end
        gxpe_pkg::RES_FULL: begin
          status_r <= gxpe_pkg::ST_FULL;
          index_r  <= '0;
          vector_r <= '0;
        end
        gxpe_pkg::RES_UNIT: begin
          status_r <= gxpe_pkg::ST_OK;
          index_r  <= gxpe_pkg::IDX_W'(unit_pos);
          vector_r <= target_r;
        end
        gxpe_pkg::RES_SCAN: begin
          status_r <= gxpe_pkg::ST_OK;
          index_r  <= units_ext + gxpe_pkg::IDX_W'(ptr_r);
          vector_r <= rdata;
        end
        default: begin
          status_r <= gxpe_pkg::ST_NOT_FOUND;
          index_r  <= '0;
          vector_r <= '0;
        end
      endcase
    end
  end

  assign res_status = status_r;
  assign res_index  = index_r;
  assign res_vector = vector_r;

endmodule

// ===== hdl/gf2_xor_program_evaluator.sv =====
// One transaction at a time. After input accept, the controller steps through S_DECODE, then:
// straight to S_DONE for a bad index, full table, unit-vector hit or empty-table miss;
// S_RD_A and S_RD_B for an append (two reads of the single memory read port);
// S_SCAN for a scanned query, over up to the appended count of entries (max 128).
// Input is taken again the cycle after the result transaction completes.
// Reset: base_count 23, no appended entries; memory contents are not cleared.
module gf2_xor_program_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,   // base_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // first_index[7:0], second_index[15:8], target_row[47:16]
  input  logic        in_tuser,    // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // entry_index[7:0], entry_vector[39:8]
  output logic [1:0]  out_tuser    // status
);

  gxpe_pkg::cmd_t cmd;
  gxpe_pkg::sts_t sts;

  logic [gxpe_pkg::IDX_W-1:0] res_index;
  logic [gxpe_pkg::VEC_W-1:0] res_vector;

  gxpe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  gxpe_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_kind    (in_tuser),
    .in_first   (in_tdata[7:0]),
    .in_second  (in_tdata[15:8]),
    .in_target  (in_tdata[47:16]),
    .cmd        (cmd),
    .sts        (sts),
    .res_status (out_tuser),
    .res_index  (res_index),
    .res_vector (res_vector)
  );

  // Pack result fields, lowest first
  assign out_tdata = {res_vector, res_index};

endmodule

// ===== dv/gf2_xor_program_evaluator_tb.sv =====
// Self-checking testbench for the GF(2) XOR program evaluator: appends and queries
// are checked against an in-bench model of the entry table. Depends on gxpe_pkg
// and the gf2_xor_program_evaluator RTL only.
module gf2_xor_program_evaluator_tb;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SINK_HOLD   = 400;
  localparam int unsigned N_PHASES    = 7;
  localparam int unsigned N_DIRECTED  = 19;

  // Per phase: base_count (written before it; the reset value for the first), item count, share of appends (percent)
  localparam logic [5:0]  PHASE_BASE  [N_PHASES] = '{6'd23, 6'd0, 6'd32, 6'd1, 6'd63, 6'd40, 6'd5};
  localparam int unsigned PHASE_ITEMS [N_PHASES] = '{130, 220, 130, 130, 220, 130, 120};
  localparam int unsigned PHASE_APP   [N_PHASES] = '{55, 85, 55, 60, 85, 50, 55};

  typedef struct packed {
    logic        kind;
    logic [7:0]  first_idx;
    logic [7:0]  second_idx;
    logic [31:0] target;
  } prog_item_t;

  typedef struct packed {
    gxpe_pkg::status_t status;
    logic [7:0]        index;
    logic [31:0]       vector;
  } entry_result_t;

  typedef struct packed {
    prog_item_t    item;
    logic          typed;
    entry_result_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [5:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // first_index[7:0], second_index[15:8], target_row[47:16]
  logic        in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // entry_index[7:0], entry_vector[39:8]
  logic [1:0]  out_tuser;  // status

  // Model of the entry table
  logic [5:0]    base_reg;
  logic [31:0]   grown_vec [gxpe_pkg::MAX_APPENDS];
  int unsigned   grown_cnt;
  entry_result_t pending_results [$];

  int unsigned error_cnt;
  bit          calm;
  bit          hold_req;

  dir_row_t dir_rows [N_DIRECTED];

  gf2_xor_program_evaluator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Number of unit vectors actually in use: 0 acts as 1, above MAX_BITS saturates
  function automatic int unsigned units_in_use();
    if (base_reg == 6'd0) return 1;
    if (base_reg > gxpe_pkg::MAX_BITS) return gxpe_pkg::MAX_BITS;
    return base_reg;
  endfunction

  function automatic logic [31:0] table_vec(int unsigned idx, int unsigned units);
    if (idx < units) return 32'd1 << idx;
    return grown_vec[idx - units];
  endfunction

  // Work out the result of one item and advance the table
  function automatic entry_result_t evaluate(prog_item_t it);
    entry_result_t r;
    int unsigned   units;
    int unsigned   total;
    int unsigned   i;
    units = units_in_use();
    total = units + grown_cnt;
    r = '{status: gxpe_pkg::ST_NOT_FOUND, index: 8'd0, vector: 32'd0};
    if (it.kind == gxpe_pkg::KIND_APPEND) begin
      if (it.first_idx >= total || it.second_idx >= total) begin
        r.status = gxpe_pkg::ST_BAD_INDEX;
      end else if (grown_cnt >= gxpe_pkg::MAX_APPENDS) begin
        r.status = gxpe_pkg::ST_FULL;
      end else begin
        r.status = gxpe_pkg::ST_OK;
        r.index  = 8'(total);
        r.vector = table_vec(it.first_idx, units) ^ table_vec(it.second_idx, units);
        grown_vec[grown_cnt] = r.vector;
        grown_cnt++;
      end
    end else begin
      // lowest matching index wins
      for (i = 0; i < total && r.status != gxpe_pkg::ST_OK; i++) begin
        if (table_vec(i, units) == it.target) begin
          r = '{status: gxpe_pkg::ST_OK, index: 8'(i), vector: it.target};
        end
      end
    end
    return r;
  endfunction

  task automatic note_error(string msg);
    error_cnt++;
    if (error_cnt <= 10) $display("%s", msg);
  endtask

  // Offer one item, hold it until accepted, then log its expected result.
  // The valid is left high; a gap or a drain lowers it.
  task automatic send_item(prog_item_t it, logic typed, entry_result_t want);
    entry_result_t pred;
    while (!calm && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {it.target, it.second_idx, it.first_idx};
    do @(posedge clk); while (!in_tready);
    pred = evaluate(it);
    if (typed) pred = want;
    pending_results.insert(pending_results.size(), pred);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_base(logic [5:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    base_reg  = value;
    grown_cnt = 0;
  endtask

  // Result sink: random back-pressure, and one long hold when asked
  initial begin : result_sink
    int unsigned k;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        for (k = 0; k < SINK_HOLD; k++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 17);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    entry_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("Unexpected result: status %0d index %0d vector %h",
                             out_tuser, out_tdata[7:0], out_tdata[39:8]));
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status || out_tdata[7:0] !== want.index ||
            out_tdata[39:8] !== want.vector) begin
          note_error($sformatf({"Mismatch: expected status %0d index %0d vector %h, ",
                                "got status %0d index %0d vector %h"},
                               want.status, want.index, want.vector,
                               out_tuser, out_tdata[7:0], out_tdata[39:8]));
        end
      end
    end
  end

  // Cycle limit
  initial begin : watchdog
    int unsigned n;
    for (n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    prog_item_t  it;
    int unsigned ph;
    int unsigned n;
    int unsigned units;
    int unsigned total;
    int unsigned pick;

    // Directed rows at the reset base_count of 23
    dir_rows = '{
      // unit vectors at both ends, a target beyond base_count, zero and all ones
      '{'{gxpe_pkg::KIND_QUERY,  8'd0,   8'd0,   32'h0000_0001}, 1'b1,
        '{gxpe_pkg::ST_OK, 8'd0, 32'h0000_0001}},
      '{'{gxpe_pkg::KIND_QUERY,  8'd0,   8'd0,   32'h0040_0000}, 1'b1,
        '{gxpe_pkg::ST_OK, 8'd22, 32'h0040_0000}},
      '{'{gxpe_pkg::KIND_QUERY,  8'd0,   8'd0,   32'h0080_0000}, 1'b1,
        '{gxpe_pkg::ST_NOT_FOUND, 8'd0, 32'd0}},
      '{'{gxpe_pkg::KIND_QUERY,  8'd0,   8'd0,   32'h0000_0000}, 1'b1,
        '{gxpe_pkg::ST_NOT_FOUND, 8'd0, 32'd0}},
      '{'{gxpe_pkg::KIND_QUERY,  8'd255, 8'd255, 32'hFFFF_FFFF}, 1'b1,
        '{gxpe_pkg::ST_NOT_FOUND, 8'd0, 32'd0}},
      // first appends, including the zero vector from one entry with itself
      '{'{gxpe_pkg::KIND_APPEND, 8'd0,   8'd1,   32'h0000_0000}, 1'b1,
        '{gxpe_pkg::ST_OK, 8'd23, 32'h0000_0003}},
      '{'{gxpe_pkg::KIND_APPEND, 8'd22,  8'd22,  32'h0000_0000}, 1'b1,
        '{gxpe_pkg::ST_OK, 8'd24, 32'h0000_0000}},
      '{'{gxpe_pkg::KIND_QUERY,  8'd0,   8'd0,   32'h0000_0000}, 1'b1,
        '{gxpe_pkg::ST_OK, 8'd24, 32'h0000_0000}},
      '{'{gxpe_pkg::KIND_APPEND, 8'd23,  8'd0,   32'hFFFF_FFFF}, 1'b0,
        '{gxpe_pkg::ST_OK, 8'd0, 32'd0}},
      '{'{gxpe_pkg::KIND_QUERY,  8'd0,   8'd0,   32'h0000_0002}, 1'b0,
        '{gxpe_pkg::ST_OK, 8'd0, 32'd0}},
      // operand just past the table, on either side, and the top index
      '{'{gxpe_pkg::KIND_APPEND, 8'd26,  8'd0,   32'h0000_0000}, 1'b1,
        '{gxpe_pkg::ST_BAD_INDEX, 8'd0, 32'd0}},
      '{'{gxpe_pkg::KIND_APPEND, 8'd0,   8'd26,  32'h0000_0000}, 1'b1,
        '{gxpe_pkg::ST_BAD_INDEX, 8'd0, 32'd0}},
      '{'{gxpe_pkg::KIND_APPEND, 8'd255, 8'd255, 32'h0000_0000}, 1'b1,
        '{gxpe_pkg::ST_BAD_INDEX, 8'd0, 32'd0}},
      '{'{gxpe_pkg::KIND_APPEND, 8'd25,  8'd24,  32'h0000_0000}, 1'b0,
        '{gxpe_pkg::ST_OK, 8'd0, 32'd0}},
      '{'{gxpe_pkg::KIND_QUERY,  8'd255, 8'd128, 32'h0000_0003}, 1'b0,
        '{gxpe_pkg::ST_OK, 8'd0, 32'd0}},
      '{'{gxpe_pkg::KIND_QUERY,  8'd0,   8'd0,   32'h8000_0000}, 1'b1,
        '{gxpe_pkg::ST_NOT_FOUND, 8'd0, 32'd0}},
      '{'{gxpe_pkg::KIND_APPEND, 8'd26,  8'd23,  32'h0000_0000}, 1'b0,
        '{gxpe_pkg::ST_OK, 8'd0, 32'd0}},
      '{'{gxpe_pkg::KIND_QUERY,  8'd0,   8'd0,   32'h0000_0001}, 1'b0,
        '{gxpe_pkg::ST_OK, 8'd0, 32'd0}},
      '{'{gxpe_pkg::KIND_APPEND, 8'd27,  8'd27,  32'h0000_0000}, 1'b0,
        '{gxpe_pkg::ST_OK, 8'd0, 32'd0}}
    };

    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 6'd0;
    in_tvalid <= 1'b0;
    in_tuser  <= 1'b0;
    in_tdata  <= '0;
    error_cnt = 0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    base_reg  = gxpe_pkg::BASE_RESET;
    grown_cnt = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < N_DIRECTED; n++) begin
      send_item(dir_rows[n].item, dir_rows[n].typed, dir_rows[n].want);
    end

    // Random phases, each under its own base_count
    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph != 0) begin
        drain_results();
        write_base(PHASE_BASE[ph]);
      end
      calm = (ph == 5);
      for (n = 0; n < PHASE_ITEMS[ph]; n++) begin
        if (ph == 2 && n == 60) drain_results();
        if (ph == 3 && n == 40) hold_req = 1'b1;
        units = units_in_use();
        total = units + grown_cnt;
        it.first_idx  = 8'($urandom);
        it.second_idx = 8'($urandom);
        it.target     = $urandom;
        if ($urandom_range(99) < PHASE_APP[ph]) begin
          it.kind = gxpe_pkg::KIND_APPEND;
          if ($urandom_range(99) < 92) begin
            it.first_idx  = 8'($urandom_range(total - 1));
            it.second_idx = 8'($urandom_range(total - 1));
          end else if ($urandom_range(1) == 1) begin
            it.first_idx  = 8'($urandom_range(255, total));
          end else begin
            it.second_idx = 8'($urandom_range(255, total));
          end
        end else begin
          it.kind = gxpe_pkg::KIND_QUERY;
          pick = $urandom_range(99);
          if (pick < 45) begin
            it.target = table_vec($urandom_range(total - 1), units);
          end else if (pick < 60) begin
            it.target = 32'd1 << $urandom_range(31);
          end else if (pick < 70) begin
            it.target = 32'd0;
          end else if (pick < 80) begin
            // near miss: an existing vector with one bit flipped
            it.target = table_vec($urandom_range(total - 1), units) ^
                        (32'd1 << $urandom_range(31));
          end
        end
        send_item(it, 1'b0, '0);
      end
    end

    drain_results();
    repeat (150) @(posedge clk);
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== gf2_xor_program_evaluator.f =====
hdl/gxpe_pkg.sv
hdl/gxpe_ram.sv
hdl/gxpe_ctrl.sv
hdl/gxpe_dp.sv
hdl/gf2_xor_program_evaluator.sv
dv/gf2_xor_program_evaluator_tb.sv
